[rtl/qsrm_pkg.sv]
// ----------------------------------------------------------------------------
// qsrm_pkg: shared constants and types
// Fixed-point widths for the scaled quaternion-to-rotation-matrix core.
// ----------------------------------------------------------------------------
package qsrm_pkg;

  // Quaternion components are signed Q2.(QUAT_WIDTH-2)
  localparam int QUAT_WIDTH  = 16;
  localparam int QUAT_FRAC   = QUAT_WIDTH - 2;
  localparam int SCALE_WIDTH = 16;
  localparam int OUT_WIDTH   = 16;
  localparam int OUT_FRAC    = 8;

  // Intermediate products and entries carry 28 fraction bits
  localparam int MID_FRAC = 28;
  localparam int PROD_W   = 2 * QUAT_WIDTH;
  localparam int PROD_SHR = (2 * QUAT_FRAC >= MID_FRAC) ? 2 * QUAT_FRAC - MID_FRAC : 0;
  localparam int PROD_SHL = (2 * QUAT_FRAC <  MID_FRAC) ? MID_FRAC - 2 * QUAT_FRAC : 0;
  // product magnitude never exceeds 4.0
  localparam int MID_W    = MID_FRAC + 4;
  localparam int WORK_W   = (PROD_W + 1 > MID_W + 1) ? PROD_W + 1 : MID_W + 1;

  // entry magnitude never exceeds 17.0
  localparam int ENT_W = MID_FRAC + 6;

  // entry x scale is split in two partial products
  localparam int LO_W     = ENT_W / 2;
  localparam int HI_W     = ENT_W - LO_W;
  localparam int PP_LO_W  = LO_W + 1 + SCALE_WIDTH;
  localparam int PP_HI_W  = HI_W + SCALE_WIDTH;
  localparam int SUM_W    = ENT_W + SCALE_WIDTH;
  localparam int SHIFT_OUT = MID_FRAC;
  localparam int RND_W    = SUM_W - SHIFT_OUT;

  localparam logic signed [RND_W-1:0] OUT_MAX = RND_W'((1 << (OUT_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0] OUT_MIN = -RND_W'(1 << (OUT_WIDTH - 1));

  // stage enables for the scale/round/saturate back end
  typedef struct packed {
    logic mul_en;
    logic out_en;
  } stage_en_t;

endpackage

[rtl/quaternion_to_scaled_rotation_matrix_core.sv]
// ----------------------------------------------------------------------------
// quaternion_to_scaled_rotation_matrix_core: quaternion to scaled 3x3 matrix
// Four-stage pipeline, each stage holding one beat, with per-stage enables.
// Throughput: one beat per cycle while out_ready is high; bubbles collapse
//   on a stall.
// Reset: synchronous, active high; clears stage valid bits only, datapath
//   registers are not reset. The core keeps no state between beats.
// ----------------------------------------------------------------------------
module quaternion_to_scaled_rotation_matrix_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [qsrm_pkg::QUAT_WIDTH-1:0]   quat_w,
  input  logic signed [qsrm_pkg::QUAT_WIDTH-1:0]   quat_x,
  input  logic signed [qsrm_pkg::QUAT_WIDTH-1:0]   quat_y,
  input  logic signed [qsrm_pkg::QUAT_WIDTH-1:0]   quat_z,
  input  logic signed [qsrm_pkg::SCALE_WIDTH-1:0]  scale_col0,
  input  logic signed [qsrm_pkg::SCALE_WIDTH-1:0]  scale_col1,
  input  logic signed [qsrm_pkg::SCALE_WIDTH-1:0]  scale_col2,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [qsrm_pkg::OUT_WIDTH-1:0]    c0_r0,
  output logic signed [qsrm_pkg::OUT_WIDTH-1:0]    c0_r1,
  output logic signed [qsrm_pkg::OUT_WIDTH-1:0]    c0_r2,
  output logic signed [qsrm_pkg::OUT_WIDTH-1:0]    c1_r0,
  output logic signed [qsrm_pkg::OUT_WIDTH-1:0]    c1_r1,
  output logic signed [qsrm_pkg::OUT_WIDTH-1:0]    c1_r2,
  output logic signed [qsrm_pkg::OUT_WIDTH-1:0]    c2_r0,
  output logic signed [qsrm_pkg::OUT_WIDTH-1:0]    c2_r1,
  output logic signed [qsrm_pkg::OUT_WIDTH-1:0]    c2_r2
);

  // Pipeline:
  //   stage 1: nine pairwise products (QUAT_WIDTH x QUAT_WIDTH each)
  //   stage 2: products rounded/aligned to 28 fraction bits, entries formed
  //   stage 3: entry x scale as two partial products (in qsrm_scale)
  //   stage 4: partial products summed, rounded to Q8.8, saturated

  localparam logic signed [qsrm_pkg::WORK_W-1:0] RND_BIAS =
    (qsrm_pkg::PROD_SHR > 0) ? (qsrm_pkg::WORK_W'(1) <<< (qsrm_pkg::PROD_SHR - 1))
                             : qsrm_pkg::WORK_W'(0);
  localparam logic signed [qsrm_pkg::ENT_W-1:0] ONE =
    qsrm_pkg::ENT_W'(1) <<< qsrm_pkg::MID_FRAC;

  // per-stage valid bits and enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  qsrm_pkg::stage_en_t scale_ctl;

  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v4;

  assign scale_ctl.mul_en = en3;
  assign scale_ctl.out_en = en4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // ---- stage 1: raw products ----
  logic signed [qsrm_pkg::PROD_W-1:0] p_xw, p_yw, p_zw, p_xy, p_zy, p_xz, p_xx, p_yy, p_zz;
  logic signed [qsrm_pkg::SCALE_WIDTH-1:0] s0_1, s1_1, s2_1;

  always_ff @(posedge clk) begin
    if (en1) begin
      p_xw <= qsrm_pkg::PROD_W'(quat_x) * qsrm_pkg::PROD_W'(quat_w);
      p_yw <= qsrm_pkg::PROD_W'(quat_y) * qsrm_pkg::PROD_W'(quat_w);
      p_zw <= qsrm_pkg::PROD_W'(quat_z) * qsrm_pkg::PROD_W'(quat_w);
      p_xy <= qsrm_pkg::PROD_W'(quat_x) * qsrm_pkg::PROD_W'(quat_y);
      p_zy <= qsrm_pkg::PROD_W'(quat_z) * qsrm_pkg::PROD_W'(quat_y);
      p_xz <= qsrm_pkg::PROD_W'(quat_x) * qsrm_pkg::PROD_W'(quat_z);
      p_xx <= qsrm_pkg::PROD_W'(quat_x) * qsrm_pkg::PROD_W'(quat_x);
      p_yy <= qsrm_pkg::PROD_W'(quat_y) * qsrm_pkg::PROD_W'(quat_y);
      p_zz <= qsrm_pkg::PROD_W'(quat_z) * qsrm_pkg::PROD_W'(quat_z);
      s0_1 <= scale_col0;
      s1_1 <= scale_col1;
      s2_1 <= scale_col2;
    end
  end

  // ---- stage 2: align to Q.28 (round half up when narrowing), build entries ----
  function automatic logic signed [qsrm_pkg::ENT_W-1:0] to_mid
    (input logic signed [qsrm_pkg::PROD_W-1:0] p);
    logic signed [qsrm_pkg::WORK_W-1:0] work;
    logic signed [qsrm_pkg::MID_W-1:0]  mid;
    work = qsrm_pkg::WORK_W'(p) + RND_BIAS;
    work = (work >>> qsrm_pkg::PROD_SHR) <<< qsrm_pkg::PROD_SHL;
    mid  = qsrm_pkg::MID_W'(work);
    return qsrm_pkg::ENT_W'(mid) <<< 1;  // doubled term
  endfunction

  logic signed [qsrm_pkg::ENT_W-1:0] m_xw, m_yw, m_zw, m_xy, m_zy, m_xz, m_xx, m_yy, m_zz;
  logic signed [qsrm_pkg::ENT_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [qsrm_pkg::SCALE_WIDTH-1:0] s0_2, s1_2, s2_2;

  always_comb begin
    m_xw = to_mid(p_xw);
    m_yw = to_mid(p_yw);
    m_zw = to_mid(p_zw);
    m_xy = to_mid(p_xy);
    m_zy = to_mid(p_zy);
    m_xz = to_mid(p_xz);
    m_xx = to_mid(p_xx);
    m_yy = to_mid(p_yy);
    m_zz = to_mid(p_zz);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      e00  <= ONE - m_yy - m_zz;
      e01  <= m_xy + m_zw;
      e02  <= m_xz - m_yw;
      e10  <= m_xy - m_zw;
      e11  <= ONE - m_xx - m_zz;
      e12  <= m_zy + m_xw;
      e20  <= m_xz + m_yw;
      e21  <= m_zy - m_xw;
      e22  <= ONE - m_xx - m_yy;
      s0_2 <= s0_1;
      s1_2 <= s1_1;
      s2_2 <= s2_1;
    end
  end

  // ---- stages 3-4: column scaling, one unit per entry ----
  qsrm_scale u_c0_r0 (.clk(clk), .ctl(scale_ctl), .entry(e00), .scale(s0_2), .result(c0_r0));
  qsrm_scale u_c0_r1 (.clk(clk), .ctl(scale_ctl), .entry(e01), .scale(s0_2), .result(c0_r1));
  qsrm_scale u_c0_r2 (.clk(clk), .ctl(scale_ctl), .entry(e02), .scale(s0_2), .result(c0_r2));
  qsrm_scale u_c1_r0 (.clk(clk), .ctl(scale_ctl), .entry(e10), .scale(s1_2), .result(c1_r0));
  qsrm_scale u_c1_r1 (.clk(clk), .ctl(scale_ctl), .entry(e11), .scale(s1_2), .result(c1_r1));
  qsrm_scale u_c1_r2 (.clk(clk), .ctl(scale_ctl), .entry(e12), .scale(s1_2), .result(c1_r2));
  qsrm_scale u_c2_r0 (.clk(clk), .ctl(scale_ctl), .entry(e20), .scale(s2_2), .result(c2_r0));
  qsrm_scale u_c2_r1 (.clk(clk), .ctl(scale_ctl), .entry(e21), .scale(s2_2), .result(c2_r1));
  qsrm_scale u_c2_r2 (.clk(clk), .ctl(scale_ctl), .entry(e22), .scale(s2_2), .result(c2_r2));

endmodule

[rtl/qsrm_scale.sv]
// ----------------------------------------------------------------------------
// qsrm_scale: scale one matrix entry
// Entry (Q.28) times scale (Q8.8), rounded to Q8.8 and saturated. Two stages.
// ----------------------------------------------------------------------------
module qsrm_scale (
  input  logic                                      clk,
  input  qsrm_pkg::stage_en_t                       ctl,
  input  logic signed [qsrm_pkg::ENT_W-1:0]         entry,
  input  logic signed [qsrm_pkg::SCALE_WIDTH-1:0]   scale,
  output logic signed [qsrm_pkg::OUT_WIDTH-1:0]     result
);

  logic signed [qsrm_pkg::LO_W:0]          lo_ext;
  logic signed [qsrm_pkg::HI_W-1:0]        hi_part;
  logic signed [qsrm_pkg::PP_LO_W-1:0]     pp_lo;
  logic signed [qsrm_pkg::PP_HI_W-1:0]     pp_hi;
  logic signed [qsrm_pkg::SUM_W-1:0]       sum;
  logic signed [qsrm_pkg::SUM_W-1:0]       sum_rnd;
  logic signed [qsrm_pkg::RND_W-1:0]       rnd;
  logic signed [qsrm_pkg::OUT_WIDTH-1:0]   result_next;

  // low half is unsigned, high half carries the sign
  assign lo_ext  = $signed({1'b0, entry[qsrm_pkg::LO_W-1:0]});
  assign hi_part = entry[qsrm_pkg::ENT_W-1:qsrm_pkg::LO_W];

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      pp_lo <= qsrm_pkg::PP_LO_W'(lo_ext) * qsrm_pkg::PP_LO_W'(scale);
      pp_hi <= qsrm_pkg::PP_HI_W'(hi_part) * qsrm_pkg::PP_HI_W'(scale);
    end
  end

  always_comb begin
    sum     = (qsrm_pkg::SUM_W'(pp_hi) <<< qsrm_pkg::LO_W) + qsrm_pkg::SUM_W'(pp_lo);
    sum_rnd = sum + (qsrm_pkg::SUM_W'(1) <<< (qsrm_pkg::SHIFT_OUT - 1));
    rnd     = qsrm_pkg::RND_W'(sum_rnd >>> qsrm_pkg::SHIFT_OUT);
    if (rnd > qsrm_pkg::OUT_MAX) begin
      result_next = qsrm_pkg::OUT_WIDTH'(qsrm_pkg::OUT_MAX);
    end else if (rnd < qsrm_pkg::OUT_MIN) begin
      result_next = qsrm_pkg::OUT_WIDTH'(qsrm_pkg::OUT_MIN);
    end else begin
      result_next = rnd[qsrm_pkg::OUT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_en) begin
      result <= result_next;
    end
  end

endmodule
